@@ rtl/mp2d_pkg.sv @@
`timescale 1ns / 1ps
package mp2d_pkg;

  localparam int DATA_WIDTH_DEF    = 16;
  localparam int MAX_FRAME_DIM_DEF = 1024;
  localparam int MAX_POOL_DEF      = 4;

  localparam int OUT_IDX_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_CFG_W  = 11;
  localparam int SML_CFG_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_H        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_W        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_BOUNDARY = 3'd6;

  localparam logic [DIM_CFG_W-1:0] RST_FRAME_DIM = 11'd32;
  localparam logic [SML_CFG_W-1:0] RST_POOL      = 3'd2;
  localparam logic [SML_CFG_W-1:0] RST_STRIDE    = 3'd2;

  typedef enum logic [4:0] {
    ST_PREP = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_IDLE = 5'b00100,
    ST_RD   = 5'b01000,
    ST_WR   = 5'b10000
  } state_t;

endpackage

@@ rtl/mp2d_pix_if.sv @@
`timescale 1ns / 1ps
interface mp2d_pix_if #(
  parameter int DATA_WIDTH = mp2d_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

@@ rtl/mp2d_res_if.sv @@
`timescale 1ns / 1ps
interface mp2d_res_if #(
  parameter int DATA_WIDTH = mp2d_pkg::DATA_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [DATA_WIDTH-1:0]     out_value;
  logic [mp2d_pkg::OUT_IDX_W-1:0]   out_row;
  logic [mp2d_pkg::OUT_IDX_W-1:0]   out_col;
  logic                             last_of_run;
  logic                             frame_done;

  modport source (output valid, output out_value, output out_row, output out_col,
                  output last_of_run, output frame_done, input ready);
  modport sink   (input valid, input out_value, input out_row, input out_col,
                  input last_of_run, input frame_done, output ready);
endinterface

@@ rtl/max_pool_2d_stream.sv @@
`timescale 1ns / 1ps
// Channel    Dir  Handshake        Payload
// in_pix     in   valid/ready      pixel_value
// out_res    out  valid/ready      out_value, out_row, out_col, last_of_run, frame_done
// cfg_*      in   cfg_we           cfg_index, cfg_wdata
// For each window an accepted pixel touches (at most MAX_POOL*MAX_POOL), the
// single-port window RAM does a memory read, then a modify/write.
// After reset and after every config write to cfg_index 0 to 6, an iterative divider
// computes the output rows and then columns, with in_pix.ready low.
// A result waiting on out_res stalls only the next window that completes.
module max_pool_2d_stream #(
  parameter int DATA_WIDTH    = mp2d_pkg::DATA_WIDTH_DEF,
  parameter int MAX_FRAME_DIM = mp2d_pkg::MAX_FRAME_DIM_DEF,
  parameter int MAX_POOL      = mp2d_pkg::MAX_POOL_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mp2d_pix_if.sink                         in_pix,
  mp2d_res_if.source                       out_res,
  input  logic                             cfg_we,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mp2d_pkg::*;

  localparam int PW    = $clog2(MAX_FRAME_DIM);
  localparam int DW1   = PW + 1;
  localparam int PLW   = $clog2(MAX_POOL + 1);
  localparam int SW    = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int AW    = SW + PW;
  localparam int DEPTH = 1 << AW;
  localparam int EW    = PW + 5;
  localparam int CW    = $clog2(DW1 + 1);

  logic [DIM_CFG_W-1:0] frame_rows_r, frame_cols_r;
  logic [SML_CFG_W-1:0] pool_h_r, pool_w_r, stride_rows_r, stride_cols_r;
  logic                 full_boundary_r;

  logic [DW1-1:0] rows_e, cols_e;
  logic [PLW-1:0] ph_e, pw_e;
  logic [2:0]     sy_e, sx_e;

  always_comb begin
    rows_e = (int'(frame_rows_r) > MAX_FRAME_DIM) ? DW1'(MAX_FRAME_DIM) : DW1'(frame_rows_r);
    if (frame_rows_r == '0) rows_e = DW1'(1);
    cols_e = (int'(frame_cols_r) > MAX_FRAME_DIM) ? DW1'(MAX_FRAME_DIM) : DW1'(frame_cols_r);
    if (frame_cols_r == '0) cols_e = DW1'(1);
    ph_e = (int'(pool_h_r) > MAX_POOL) ? PLW'(MAX_POOL) : PLW'(pool_h_r);
    if (pool_h_r == '0) ph_e = PLW'(1);
    pw_e = (int'(pool_w_r) > MAX_POOL) ? PLW'(MAX_POOL) : PLW'(pool_w_r);
    if (pool_w_r == '0) pw_e = PLW'(1);
    sy_e = (stride_rows_r == '0) ? 3'd1 : stride_rows_r;
    sx_e = (stride_cols_r == '0) ? 3'd1 : stride_cols_r;
  end

  state_t st_r, st_nxt;

  logic           cfg_hit;
  assign cfg_hit = cfg_we && (cfg_index == REG_FRAME_ROWS || cfg_index == REG_FRAME_COLS ||
                   cfg_index == REG_POOL_H || cfg_index == REG_POOL_W ||
                   cfg_index == REG_STRIDE_ROWS || cfg_index == REG_STRIDE_COLS ||
                   cfg_index == REG_FULL_BOUNDARY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r    <= RST_FRAME_DIM;
      frame_cols_r    <= RST_FRAME_DIM;
      pool_h_r        <= RST_POOL;
      pool_w_r        <= RST_POOL;
      stride_rows_r   <= RST_STRIDE;
      stride_cols_r   <= RST_STRIDE;
      full_boundary_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_ROWS:    frame_rows_r    <= DIM_CFG_W'(cfg_wdata);
        REG_FRAME_COLS:    frame_cols_r    <= DIM_CFG_W'(cfg_wdata);
        REG_POOL_H:        pool_h_r        <= SML_CFG_W'(cfg_wdata);
        REG_POOL_W:        pool_w_r        <= SML_CFG_W'(cfg_wdata);
        REG_STRIDE_ROWS:   stride_rows_r   <= SML_CFG_W'(cfg_wdata);
        REG_STRIDE_COLS:   stride_cols_r   <= SML_CFG_W'(cfg_wdata);
        REG_FULL_BOUNDARY: full_boundary_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // output-count divider: rows pass then cols pass
  logic           dv_sel_r;
  logic [DW1-1:0] dv_num_r;
  logic [3:0]     dv_rem_r;
  logic [CW-1:0]  dv_cnt_r;
  logic [DW1-1:0] orows_r, ocols_r;
  logic [2:0]     dv_s;
  logic [3:0]     dv_sh;
  logic           dv_ge;
  logic [DW1-1:0] dv_dend;

  assign dv_s    = dv_sel_r ? sx_e : sy_e;
  assign dv_sh   = {dv_rem_r[2:0], dv_num_r[DW1-1]};
  assign dv_ge   = dv_sh >= {1'b0, dv_s};
  assign dv_dend = (dv_sel_r ? cols_e : rows_e) - DW1'(full_boundary_r);

  // position tracking: r/sy, c/sx, (r-ph)/sy and (c-pw)/sx kept as quotient/remainder
  logic [PW-1:0] r_r, c_r, qr_r, qc_r, qlr_r, qlc_r;
  logic [2:0]    rr_r, rc_r, rlr_r, rlc_r;

  logic [PW-1:0] cr_r, cc_r, ii_r, jj_r, ilo_r, ihi_r, jlo_r, jhi_r;
  logic [PW-1:0] ilo_w, ihi_w, jlo_w, jhi_w;
  logic signed [DATA_WIDTH-1:0] px_r;
  logic          has_win, accept;

  always_comb begin
    ihi_w = (DW1'(qr_r) > orows_r - DW1'(1)) ? PW'(orows_r - DW1'(1)) : qr_r;
    jhi_w = (DW1'(qc_r) > ocols_r - DW1'(1)) ? PW'(ocols_r - DW1'(1)) : qc_r;
    ilo_w = (DW1'(r_r) < DW1'(ph_e)) ? '0 : qlr_r + PW'(1);
    jlo_w = (DW1'(c_r) < DW1'(pw_e)) ? '0 : qlc_r + PW'(1);
  end

  assign has_win = (orows_r != '0) && (ocols_r != '0) && (ilo_w <= ihi_w) && (jlo_w <= jhi_w);
  assign accept  = in_pix.valid && in_pix.ready;
  assign in_pix.ready = (st_r == ST_IDLE);

  function automatic logic win_ends(input logic [PW-1:0] idx, input logic [2:0] s,
                                    input logic [PLW-1:0] p, input logic [DW1-1:0] n,
                                    input logic [PW-1:0] pos);
    logic [EW-1:0] e;
    e = EW'(idx) * EW'(s) + EW'(p);
    if (e > EW'(n)) e = EW'(n);
    return e == EW'(pos) + EW'(1);
  endfunction

  // window RAM
  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_q;
  logic [AW-1:0]                addr;
  logic signed [DATA_WIDTH-1:0] upd;
  logic                         seed, emit, go, mem_we, ld_out, row_last, col_last;

  assign addr = {ii_r[SW-1:0], jj_r};
  assign seed = (EW'(ii_r) * EW'(sy_e) == EW'(cr_r)) && (EW'(jj_r) * EW'(sx_e) == EW'(cc_r));
  assign upd  = (seed || px_r > mem_q) ? px_r : mem_q;
  assign emit = win_ends(ii_r, sy_e, ph_e, rows_e, cr_r) &&
                win_ends(jj_r, sx_e, pw_e, cols_e, cc_r);
  assign row_last = (ii_r == ihi_r) || !win_ends(ii_r + PW'(1), sy_e, ph_e, rows_e, cr_r);
  assign col_last = (jj_r == jhi_r) || !win_ends(jj_r + PW'(1), sx_e, pw_e, cols_e, cc_r);
  assign go     = !emit || !out_res.valid || out_res.ready;
  assign mem_we = (st_r == ST_WR) && go;
  assign ld_out = mem_we && emit;

  always_ff @(posedge clk) begin
    if (st_r == ST_RD) mem_q <= mem[addr];
    if (mem_we) mem[addr] <= upd;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_PREP: st_nxt = ST_DIV;
      ST_DIV:  if (dv_cnt_r == CW'(DW1 - 1)) st_nxt = dv_sel_r ? ST_IDLE : ST_PREP;
      ST_IDLE: if (accept && has_win) st_nxt = ST_RD;
      ST_RD:   st_nxt = ST_WR;
      ST_WR:   if (go) st_nxt = (jj_r == jhi_r && ii_r == ihi_r) ? ST_IDLE : ST_RD;
      default: st_nxt = ST_PREP;
    endcase
    if (cfg_hit) st_nxt = ST_PREP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_PREP;
      dv_sel_r <= 1'b0;
      dv_cnt_r <= '0;
      orows_r  <= '0;
      ocols_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_hit) begin
        dv_sel_r <= 1'b0;
      end else if (st_r == ST_PREP) begin
        dv_num_r <= dv_dend;
        dv_rem_r <= '0;
        dv_cnt_r <= '0;
      end else if (st_r == ST_DIV) begin
        dv_num_r <= {dv_num_r[DW1-2:0], dv_ge};
        dv_rem_r <= dv_ge ? dv_sh - {1'b0, dv_s} : dv_sh;
        dv_cnt_r <= dv_cnt_r + CW'(1);
        if (dv_cnt_r == CW'(DW1 - 1)) begin
          if (dv_sel_r) ocols_r <= {dv_num_r[DW1-2:0], dv_ge} + DW1'(full_boundary_r);
          else          orows_r <= {dv_num_r[DW1-2:0], dv_ge} + DW1'(full_boundary_r);
          dv_sel_r <= !dv_sel_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      r_r <= '0; c_r <= '0; qr_r <= '0; qc_r <= '0; qlr_r <= '0; qlc_r <= '0;
      rr_r <= '0; rc_r <= '0; rlr_r <= '0; rlc_r <= '0;
    end else if (accept) begin
      if (DW1'(c_r) + DW1'(1) == cols_e) begin
        c_r <= '0; qc_r <= '0; rc_r <= '0; qlc_r <= '0; rlc_r <= '0;
        if (DW1'(r_r) + DW1'(1) == rows_e) begin
          r_r <= '0; qr_r <= '0; rr_r <= '0; qlr_r <= '0; rlr_r <= '0;
        end else begin
          r_r <= r_r + PW'(1);
          if (rr_r + 3'd1 == sy_e) begin
            rr_r <= '0; qr_r <= qr_r + PW'(1);
          end else begin
            rr_r <= rr_r + 3'd1;
          end
          if (DW1'(r_r) + DW1'(1) == DW1'(ph_e)) begin
            qlr_r <= '0; rlr_r <= '0;
          end else if (DW1'(r_r) + DW1'(1) > DW1'(ph_e)) begin
            if (rlr_r + 3'd1 == sy_e) begin
              rlr_r <= '0; qlr_r <= qlr_r + PW'(1);
            end else begin
              rlr_r <= rlr_r + 3'd1;
            end
          end
        end
      end else begin
        c_r <= c_r + PW'(1);
        if (rc_r + 3'd1 == sx_e) begin
          rc_r <= '0; qc_r <= qc_r + PW'(1);
        end else begin
          rc_r <= rc_r + 3'd1;
        end
        if (DW1'(c_r) + DW1'(1) == DW1'(pw_e)) begin
          qlc_r <= '0; rlc_r <= '0;
        end else if (DW1'(c_r) + DW1'(1) > DW1'(pw_e)) begin
          if (rlc_r + 3'd1 == sx_e) begin
            rlc_r <= '0; qlc_r <= qlc_r + PW'(1);
          end else begin
            rlc_r <= rlc_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r  <= in_pix.pixel_value;
      cr_r  <= r_r;
      cc_r  <= c_r;
      ii_r  <= ilo_w;
      jj_r  <= jlo_w;
      ilo_r <= ilo_w;
      ihi_r <= ihi_w;
      jlo_r <= jlo_w;
      jhi_r <= jhi_w;
    end else if (mem_we) begin
      if (jj_r == jhi_r) begin
        jj_r <= jlo_r;
        ii_r <= ii_r + PW'(1);
      end else begin
        jj_r <= jj_r + PW'(1);
      end
    end
  end

  // result register
  logic                         out_valid_r, last_r, done_r;
  logic signed [DATA_WIDTH-1:0] val_r;
  logic [OUT_IDX_W-1:0]         orow_r, ocol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
    if (ld_out) begin
      val_r  <= upd;
      orow_r <= OUT_IDX_W'(ii_r);
      ocol_r <= OUT_IDX_W'(jj_r);
      last_r <= row_last && col_last;
      done_r <= (DW1'(ii_r) == orows_r - DW1'(1)) && (DW1'(jj_r) == ocols_r - DW1'(1));
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.out_value   = val_r;
  assign out_res.out_row     = orow_r;
  assign out_res.out_col     = ocol_r;
  assign out_res.last_of_run = last_r;
  assign out_res.frame_done  = done_r;

  a_frame_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> last_r)
    else $error("frame_done without last_of_run");

  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RD |-> ii_r >= ilo_r && ii_r <= ihi_r && jj_r >= jlo_r && jj_r <= jhi_r)
    else $error("window index out of range");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> $past(st_r) == ST_RD || $past(st_r) == ST_WR)
    else $error("window write without read");

endmodule

@@ tb/tb_max_pool_2d_stream.sv @@
`timescale 1ns / 1ps
module tb_max_pool_2d_stream;
  import mp2d_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int MAX_DIM = MAX_FRAME_DIM_DEF;
  localparam int MAX_P = MAX_POOL_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS = 24;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic signed [DW-1:0]  value;
    logic [OUT_IDX_W-1:0]  row;
    logic [OUT_IDX_W-1:0]  col;
    logic                  last;
    logic                  done;
  } pool_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mp2d_pix_if #(.DATA_WIDTH(DW)) pix ();
  mp2d_res_if #(.DATA_WIDTH(DW)) res ();

  max_pool_2d_stream dut (
    .clk(clk), .rst_n(rst_n), .in_pix(pix), .out_res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow configuration and window state
  int unsigned sh_rows, sh_cols, sh_ph, sh_pw, sh_sy, sh_sx, sh_full;
  int unsigned pos_r, pos_c;
  logic signed [DW-1:0] win_max [MAX_P*MAX_DIM];

  pool_res_t pending_windows[$];
  int errors;
  int cycles;
  int idle_pct;
  int stall_pct;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    res.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    pool_res_t got, exp_r;
    if (rst_n && res.valid && res.ready) begin
      got = '{res.out_value, res.out_row, res.out_col, res.last_of_run, res.frame_done};
      if (pending_windows.size() == 0) begin
        report($sformatf("unexpected transaction %p", got));
      end else begin
        exp_r = pending_windows.pop_front();
        if (got.value !== exp_r.value)
          report($sformatf("value got %0d exp %0d", got.value, exp_r.value));
        if (got.row !== exp_r.row)
          report($sformatf("row got %0d exp %0d", got.row, exp_r.row));
        if (got.col !== exp_r.col)
          report($sformatf("col got %0d exp %0d", got.col, exp_r.col));
        if (got.last !== exp_r.last)
          report($sformatf("last_of_run got %0b exp %0b", got.last, exp_r.last));
        if (got.done !== exp_r.done)
          report($sformatf("frame_done got %0b exp %0b", got.done, exp_r.done));
      end
    end
  end

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic pool_pixel(input logic signed [DW-1:0] px);
    int unsigned rows, cols, ph, pw, sy, sx, orows, ocols;
    int unsigned i_lo, i_hi, j_lo, j_hi, last_r, last_c, slot, n, first;
    pool_res_t w;
    rows = clamp(sh_rows, MAX_DIM);
    cols = clamp(sh_cols, MAX_DIM);
    ph = clamp(sh_ph, MAX_P);
    pw = clamp(sh_pw, MAX_P);
    sy = (sh_sy == 0) ? 1 : sh_sy;
    sx = (sh_sx == 0) ? 1 : sh_sx;
    orows = sh_full ? (rows - 1) / sy + 1 : rows / sy;
    ocols = sh_full ? (cols - 1) / sx + 1 : cols / sx;
    n = 0;
    first = pending_windows.size();
    if (orows > 0 && ocols > 0) begin
      i_hi = pos_r / sy;
      j_hi = pos_c / sx;
      i_lo = (pos_r < ph) ? 0 : (pos_r - ph) / sy + 1;
      j_lo = (pos_c < pw) ? 0 : (pos_c - pw) / sx + 1;
      if (i_hi >= orows) i_hi = orows - 1;
      if (j_hi >= ocols) j_hi = ocols - 1;
      for (int unsigned ii = i_lo; ii <= i_hi; ii++) begin
        last_r = ((ii * sy + ph < rows) ? ii * sy + ph : rows) - 1;
        for (int unsigned jj = j_lo; jj <= j_hi; jj++) begin
          last_c = ((jj * sx + pw < cols) ? jj * sx + pw : cols) - 1;
          slot = (ii % MAX_P) * MAX_DIM + jj;
          if (slot < MAX_P * MAX_DIM) begin
            if (pos_r == ii * sy && pos_c == jj * sx) win_max[slot] = px;
            else if (px > win_max[slot]) win_max[slot] = px;
            if (last_r == pos_r && last_c == pos_c && n < MAX_P * MAX_P) begin
              w.value = win_max[slot];
              w.row = ii[OUT_IDX_W-1:0];
              w.col = jj[OUT_IDX_W-1:0];
              w.last = 1'b0;
              w.done = (ii == orows - 1 && jj == ocols - 1);
              pending_windows.push_back(w);
              n++;
            end
          end
        end
      end
      if (n > 0) pending_windows[first + n - 1].last = 1'b1;
    end
    pos_c++;
    if (pos_c >= cols) begin
      pos_c = 0;
      pos_r++;
      if (pos_r >= rows) pos_r = 0;
    end
  endtask

  task automatic send_pixel(input logic signed [DW-1:0] px);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_value <= px;
    do @(posedge clk); while (!pix.ready);
    pool_pixel(px);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    pix.valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_ROWS:    sh_rows = val & 11'h7ff;
      REG_FRAME_COLS:    sh_cols = val & 11'h7ff;
      REG_POOL_H:        sh_ph = val & 7;
      REG_POOL_W:        sh_pw = val & 7;
      REG_STRIDE_ROWS:   sh_sy = val & 7;
      REG_STRIDE_COLS:   sh_sx = val & 7;
      REG_FULL_BOUNDARY: sh_full = val & 1;
      default: return;
    endcase
    pos_r = 0;
    pos_c = 0;
  endtask

  task automatic setup(input int unsigned rows, cols, ph, pw, sy, sx, full);
    write_reg(REG_FRAME_ROWS, rows);
    write_reg(REG_FRAME_COLS, cols);
    write_reg(REG_POOL_H, ph);
    write_reg(REG_POOL_W, pw);
    write_reg(REG_STRIDE_ROWS, sy);
    write_reg(REG_STRIDE_COLS, sx);
    write_reg(REG_FULL_BOUNDARY, full);
  endtask

  task automatic test_reset_defaults();
    send_pixel(16'sh8000);
    send_pixel(16'sh7fff);
  endtask

  task automatic test_clipped_ceil();
    setup(3, 3, 2, 2, 2, 2, 1);
    for (int k = 0; k < 9; k++) send_pixel((k == 4) ? 16'sh7fff : DW'(-1 - k));
  endtask

  task automatic test_sixteen_windows();
    setup(4, 4, 7, 7, 1, 1, 1);
    for (int k = 0; k < 16; k++) send_pixel(DW'($urandom));
  endtask

  task automatic test_degenerate_sizes();
    setup(0, 2047, 0, 0, 0, 0, 1);
    send_pixel(16'sh0000);
    send_pixel(16'sh8000);
    write_reg(REG_NONE, 11'h555);
    send_pixel(16'sh7fff);
  endtask

  task automatic test_empty_output();
    setup(2, 2, 1, 1, 7, 7, 0);
    for (int k = 0; k < 4; k++) send_pixel(DW'($urandom));
  endtask

  task automatic test_random_phase(input int idle, input int stall, input bit hold_off);
    int unsigned rows, cols, count, n_px;
    idle_pct = idle;
    stall_pct = stall;
    count = 0;
    while (count < PHASE_ITEMS) begin
      rows = $urandom_range(6, 1);
      cols = $urandom_range(7, 1);
      setup(rows, cols, $urandom_range(7), $urandom_range(7),
            ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(3, 1),
            ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(3, 1),
            $urandom_range(1));
      n_px = rows * cols + $urandom_range(rows * cols);
      for (int unsigned k = 0; k < n_px && count < PHASE_ITEMS; k++) begin
        send_pixel(DW'($urandom));
        count++;
        if (hold_off && count == 10) begin
          @(negedge clk);
          pix.valid <= 1'b0;
          while (pending_windows.size() != 0) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    pix.valid = 1'b0;
    pix.pixel_value = '0;
    idle_pct = 0;
    stall_pct = 0;
    sh_rows = RST_FRAME_DIM;
    sh_cols = RST_FRAME_DIM;
    sh_ph = RST_POOL;
    sh_pw = RST_POOL;
    sh_sy = RST_STRIDE;
    sh_sx = RST_STRIDE;
    sh_full = 1;
    pos_r = 0;
    pos_c = 0;
    for (int k = 0; k < MAX_P * MAX_DIM; k++) win_max[k] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_clipped_ceil();
    test_sixteen_windows();
    test_degenerate_sizes();
    test_empty_output();
    test_random_phase(0, 0, 0);
    test_random_phase(53, 0, 1);
    test_random_phase(0, 53, 0);
    test_random_phase(30, 30, 0);

    wait_drained();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
